FILE: sv/assert_macros.svh
// Assertion macros shared by the color ramp generator RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must never hold outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error("assertion failed: condition must never hold");

// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: implication does not hold");

// The antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication does not hold");

`endif

FILE: sv/rcrg_pkg.sv
// Shared types and constants of the color ramp generator.
// Depends on nothing; used by every module of the block.
package rcrg_pkg;

	localparam int CHAN_W          = 8;
	localparam int NUM_CHAN        = 3;
	localparam int STEP_W          = 6;
	localparam int MAX_STEPS_DEF   = 63;
	localparam int QUEUE_DEPTH_DEF = 2;

	typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] color_t;

	typedef enum logic [1:0] {
		FS_IDLE,
		FS_DIV,
		FS_PUSH
	} front_state_t;

	typedef enum logic {
		BS_IDLE,
		BS_RUN
	} back_state_t;

	typedef struct packed {
		color_t                    start;
		color_t                    stop;
		color_t                    inc;
		logic [NUM_CHAN-1:0]       down;
		logic [STEP_W-1:0]         n;
		logic                      emit;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

FILE: sv/rcrg_front.sv
// Front part: accepts a ramp request, clamps the step count and divides the
// channel differences by it, one quotient bit per cycle. Depends on rcrg_pkg.
module rcrg_front #(
	parameter int MAX_STEPS = rcrg_pkg::MAX_STEPS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [23:0]                  start_color,
	input  logic [23:0]                  end_color,
	input  logic [rcrg_pkg::STEP_W-1:0]  step_count,
	input  logic                         emit_start,
	input  rcrg_pkg::q_status_t          q_stat,
	output logic                         q_push,
	output rcrg_pkg::job_t               q_job
);

	localparam int CW = rcrg_pkg::CHAN_W;
	localparam int NC = rcrg_pkg::NUM_CHAN;
	localparam int SW = rcrg_pkg::STEP_W;
	localparam int BW = $clog2(CW);

	rcrg_pkg::front_state_t state_q, state_d;
	rcrg_pkg::color_t       start_q, stop_q, quo_q;
	logic [NC-1:0][SW-1:0]  rem_q;
	logic [NC-1:0]          down_q;
	logic [SW-1:0]          n_q;
	logic                   emit_q;
	logic [BW-1:0]          bit_q;
	logic                   accept;
	logic [SW-1:0]          n_clamp;
	rcrg_pkg::color_t       start_in, stop_in;
	logic [NC-1:0][SW:0]    trial;
	logic [NC-1:0]          qbit;

	assign start_in = rcrg_pkg::color_t'(start_color);
	assign stop_in  = rcrg_pkg::color_t'(end_color);
	assign accept   = push && !full;

	always_comb begin
		if (step_count == '0) begin
			n_clamp = SW'(1);
		end else if (step_count > SW'(MAX_STEPS)) begin
			n_clamp = SW'(MAX_STEPS);
		end else begin
			n_clamp = step_count;
		end
	end

	always_comb begin
		for (int c = 0; c < NC; c++) begin
			trial[c] = {rem_q[c], quo_q[c][CW-1]};
			qbit[c]  = (trial[c] >= {1'b0, n_q});
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rcrg_pkg::FS_IDLE: begin
				if (accept) begin
					state_d = rcrg_pkg::FS_DIV;
				end
			end
			rcrg_pkg::FS_DIV: begin
				if (bit_q == BW'(CW - 1)) begin
					state_d = rcrg_pkg::FS_PUSH;
				end
			end
			rcrg_pkg::FS_PUSH: begin
				if (!q_stat.full) begin
					state_d = rcrg_pkg::FS_IDLE;
				end
			end
			default: state_d = rcrg_pkg::FS_IDLE;
		endcase
	end

	always_comb begin
		full   = 1'b1;
		q_push = 1'b0;
		unique case (state_q)
			rcrg_pkg::FS_IDLE: full = 1'b0;
			rcrg_pkg::FS_DIV:  full = 1'b1;
			rcrg_pkg::FS_PUSH: q_push = !q_stat.full;
			default:           full = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rcrg_pkg::FS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			start_q <= start_in;
			stop_q  <= stop_in;
			n_q     <= n_clamp;
			emit_q  <= emit_start;
			bit_q   <= '0;
			for (int c = 0; c < NC; c++) begin
				down_q[c] <= start_in[c] > stop_in[c];
				quo_q[c]  <= (start_in[c] > stop_in[c]) ? start_in[c] - stop_in[c]
				                                        : stop_in[c] - start_in[c];
				rem_q[c]  <= '0;
			end
		end else if (state_q == rcrg_pkg::FS_DIV) begin
			bit_q <= bit_q + BW'(1);
			for (int c = 0; c < NC; c++) begin
				quo_q[c] <= {quo_q[c][CW-2:0], qbit[c]};
				rem_q[c] <= qbit[c] ? SW'(trial[c] - {1'b0, n_q}) : trial[c][SW-1:0];
			end
		end
	end

	assign q_job.start = start_q;
	assign q_job.stop  = stop_q;
	assign q_job.inc   = quo_q;
	assign q_job.down  = down_q;
	assign q_job.n     = n_q;
	assign q_job.emit  = emit_q;

endmodule

FILE: sv/rcrg_queue.sv
// Short job queue between the front and back parts of the ramp generator.
// Depends on rcrg_pkg for the job and status types.
module rcrg_queue #(
	parameter int DEPTH = rcrg_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr,
	input  rcrg_pkg::job_t      wr_job,
	input  logic                rd,
	output rcrg_pkg::job_t      rd_job,
	output rcrg_pkg::q_status_t stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	rcrg_pkg::job_t mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0] cnt_q;

	assign stat.full  = (cnt_q == CNTW'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rd_job     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + CNTW'(1);
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - CNTW'(1);
			end
		end
	end

endmodule

FILE: sv/rcrg_back.sv
// Back part: takes a divided job from the queue and emits the ramp colors,
// one per cycle while pop keeps up, through an output register. Depends on rcrg_pkg.
module rcrg_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rcrg_pkg::q_status_t          q_stat,
	input  rcrg_pkg::job_t               q_job,
	output logic                         q_pop,
	output logic                         empty,
	input  logic                         pop,
	output logic [rcrg_pkg::CHAN_W-1:0]  red,
	output logic [rcrg_pkg::CHAN_W-1:0]  green,
	output logic [rcrg_pkg::CHAN_W-1:0]  blue,
	output logic                         last
);

	localparam int NC = rcrg_pkg::NUM_CHAN;
	localparam int SW = rcrg_pkg::STEP_W;

	rcrg_pkg::back_state_t state_q, state_d;
	rcrg_pkg::job_t        job_q;
	rcrg_pkg::color_t      cur_q, nxt, out_q;
	logic [SW-1:0]         idx_q;
	logic                  first_q;
	logic                  valid_q;
	logic                  last_q;
	logic                  adv;
	logic                  stepping;

	assign adv      = (state_q == rcrg_pkg::BS_RUN) && (!valid_q || pop);
	assign stepping = !first_q && (idx_q < job_q.n);

	always_comb begin
		for (int c = 0; c < NC; c++) begin
			nxt[c] = job_q.down[c] ? cur_q[c] - job_q.inc[c] : cur_q[c] + job_q.inc[c];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rcrg_pkg::BS_IDLE: begin
				if (!q_stat.empty) begin
					state_d = rcrg_pkg::BS_RUN;
				end
			end
			rcrg_pkg::BS_RUN: begin
				if (adv && !first_q && !stepping) begin
					state_d = rcrg_pkg::BS_IDLE;
				end
			end
			default: state_d = rcrg_pkg::BS_IDLE;
		endcase
	end

	always_comb begin
		q_pop = 1'b0;
		unique case (state_q)
			rcrg_pkg::BS_IDLE: q_pop = !q_stat.empty;
			rcrg_pkg::BS_RUN:  q_pop = 1'b0;
			default:           q_pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rcrg_pkg::BS_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (adv) begin
				valid_q <= 1'b1;
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q   <= q_job;
			cur_q   <= q_job.start;
			idx_q   <= SW'(1);
			first_q <= q_job.emit;
		end else if (adv) begin
			if (first_q) begin
				out_q   <= cur_q;
				last_q  <= 1'b0;
				first_q <= 1'b0;
			end else if (stepping) begin
				out_q  <= nxt;
				last_q <= 1'b0;
				cur_q  <= nxt;
				idx_q  <= idx_q + SW'(1);
			end else begin
				out_q  <= job_q.stop;
				last_q <= 1'b1;
			end
		end
	end

	assign empty = !valid_q;
	assign red   = out_q[2];
	assign green = out_q[1];
	assign blue  = out_q[0];
	assign last  = last_q;

endmodule

FILE: sv/rgb_color_ramp_generator_core.sv
// Top level of the RGB888 color ramp generator.
// Depends on rcrg_pkg, rcrg_front, rcrg_queue, rcrg_back and assert_macros.svh.

// Each request beat yields its ramp as one result beat per cycle while pop
// keeps up: the start color when emit_start is set, then n-1 accumulated
// colors (n is step_count, zero taken as one), then the end color with last
// set. The front takes a request, divides all three channel differences by
// n bit-serially and hands the job to the queue (two entries by default),
// waiting while it is full; full stays high until the job is queued. The
// back drains the queue independently, so a new request can be taken while
// the back still emits the previous ramp.
`include "assert_macros.svh"

module rgb_color_ramp_generator_core #(
	parameter int MAX_STEPS   = rcrg_pkg::MAX_STEPS_DEF,
	parameter int QUEUE_DEPTH = rcrg_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [23:0]                  start_color,
	input  logic [23:0]                  end_color,
	input  logic [rcrg_pkg::STEP_W-1:0]  step_count,
	input  logic                         emit_start,
	output logic                         empty,
	input  logic                         pop,
	output logic [rcrg_pkg::CHAN_W-1:0]  red,
	output logic [rcrg_pkg::CHAN_W-1:0]  green,
	output logic [rcrg_pkg::CHAN_W-1:0]  blue,
	output logic                         last
);

	rcrg_pkg::q_status_t q_stat;
	rcrg_pkg::job_t      wr_job, rd_job;
	logic                q_push, q_pop;

	rcrg_front #(
		.MAX_STEPS(MAX_STEPS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.start_color(start_color),
		.end_color  (end_color),
		.step_count (step_count),
		.emit_start (emit_start),
		.q_stat     (q_stat),
		.q_push     (q_push),
		.q_job      (wr_job)
	);

	rcrg_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (q_push),
		.wr_job(wr_job),
		.rd    (q_pop),
		.rd_job(rd_job),
		.stat  (q_stat)
	);

	rcrg_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.q_stat(q_stat),
		.q_job (rd_job),
		.q_pop (q_pop),
		.empty (empty),
		.pop   (pop),
		.red   (red),
		.green (green),
		.blue  (blue),
		.last  (last)
	);

	`ASSERT_NEVER(a_no_push_when_full, clk, arst_n, q_push && q_stat.full)
	`ASSERT_IMPLIES(a_pop_needs_job, clk, arst_n, q_pop, !q_stat.empty)
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, push && !full, full)

endmodule

FILE: verif/rgb_color_ramp_generator_core_tb.sv
// Self-checking testbench for rgb_color_ramp_generator_core.
// Depends on rcrg_pkg and the core; it predicts every ramp color and checks
// each result beat in order.
module rgb_color_ramp_generator_core_tb;

	typedef struct {
		logic [rcrg_pkg::CHAN_W-1:0] red;
		logic [rcrg_pkg::CHAN_W-1:0] green;
		logic [rcrg_pkg::CHAN_W-1:0] blue;
		logic                        last;
	} ramp_color_t;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        push;
	logic                        full;
	logic [23:0]                 start_color;
	logic [23:0]                 end_color;
	logic [rcrg_pkg::STEP_W-1:0] step_count;
	logic                        emit_start;
	logic                        empty;
	logic                        pop = 1'b0;
	logic [rcrg_pkg::CHAN_W-1:0] red;
	logic [rcrg_pkg::CHAN_W-1:0] green;
	logic [rcrg_pkg::CHAN_W-1:0] blue;
	logic                        last;

	ramp_color_t ramp_expected[$];
	int          send_idle_pct;
	int          pop_idle_pct;
	int          mismatches;

	rgb_color_ramp_generator_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.start_color (start_color),
		.end_color   (end_color),
		.step_count  (step_count),
		.emit_start  (emit_start),
		.empty       (empty),
		.pop         (pop),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.last        (last)
	);

	always #1 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		mismatches++;
	endtask

	function automatic void predict_ramp(input rcrg_pkg::color_t from,
			input rcrg_pkg::color_t to, input logic [rcrg_pkg::STEP_W-1:0] steps,
			input logic emit);
		int          n;
		int          inc[rcrg_pkg::NUM_CHAN];
		logic        down[rcrg_pkg::NUM_CHAN];
		logic [7:0]  cur[rcrg_pkg::NUM_CHAN];
		ramp_color_t c;
		n = (steps == 0) ? 1 : int'(steps);
		if (n > rcrg_pkg::MAX_STEPS_DEF) begin
			n = rcrg_pkg::MAX_STEPS_DEF;
		end
		for (int ch = 0; ch < rcrg_pkg::NUM_CHAN; ch++) begin
			cur[ch] = from[ch];
			down[ch] = from[ch] > to[ch];
			inc[ch] = down[ch] ? (int'(from[ch]) - int'(to[ch])) / n
				: (int'(to[ch]) - int'(from[ch])) / n;
		end
		if (emit) begin
			c = '{red: from[2], green: from[1], blue: from[0], last: 1'b0};
			ramp_expected.push_back(c);
		end
		for (int i = 1; i < n; i++) begin
			for (int ch = 0; ch < rcrg_pkg::NUM_CHAN; ch++) begin
				cur[ch] = down[ch] ? cur[ch] - inc[ch][7:0] : cur[ch] + inc[ch][7:0];
			end
			c = '{red: cur[2], green: cur[1], blue: cur[0], last: 1'b0};
			ramp_expected.push_back(c);
		end
		c = '{red: to[2], green: to[1], blue: to[0], last: 1'b1};
		ramp_expected.push_back(c);
	endfunction

	task automatic send_ramp(input logic [23:0] from, input logic [23:0] to,
			input logic [rcrg_pkg::STEP_W-1:0] steps, input logic emit);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push        <= 1'b1;
		start_color <= from;
		end_color   <= to;
		step_count  <= steps;
		emit_start  <= emit;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
		predict_ramp(from, to, steps, emit);
	endtask

	task automatic drain_ramps();
		push <= 1'b0;
		while (ramp_expected.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
	endtask

	task automatic check_color();
		ramp_color_t want;
		if (ramp_expected.size() == 0) begin
			report_mismatch("result beat with no color expected");
		end else begin
			want = ramp_expected.pop_front();
			if (red !== want.red) begin
				report_mismatch($sformatf("red got %0h, expected %0h", red, want.red));
			end
			if (green !== want.green) begin
				report_mismatch($sformatf("green got %0h, expected %0h", green, want.green));
			end
			if (blue !== want.blue) begin
				report_mismatch($sformatf("blue got %0h, expected %0h", blue, want.blue));
			end
			if (last !== want.last) begin
				report_mismatch($sformatf("last got %0h, expected %0h", last, want.last));
			end
		end
	endtask

	always @(posedge clk) begin
		if (pop && !empty) begin
			check_color();
		end
		pop <= ($urandom_range(0, 99) >= pop_idle_pct);
	end

	function automatic logic [23:0] random_color();
		logic [23:0] c;
		for (int ch = 0; ch < rcrg_pkg::NUM_CHAN; ch++) begin
			case ($urandom_range(0, 5))
				0: c[ch*8 +: 8] = 8'h00;
				1: c[ch*8 +: 8] = 8'hff;
				default: c[ch*8 +: 8] = 8'($urandom_range(0, 255));
			endcase
		end
		return c;
	endfunction

	task automatic test_zero_and_one_step();
		send_ramp(24'h000000, 24'hffffff, 6'd0, 1'b0);
		send_ramp(24'h000000, 24'hffffff, 6'd0, 1'b1);
		send_ramp(24'h123456, 24'h123456, 6'd1, 1'b1);
		send_ramp(24'h123456, 24'h123456, 6'd1, 1'b0);
		send_ramp(24'hffffff, 24'h000000, 6'd1, 1'b1);
		send_ramp(24'h5a5a5a, 24'ha5a5a5, 6'd0, 1'b1);
		drain_ramps();
	endtask

	task automatic test_full_span();
		send_ramp(24'h000000, 24'hffffff, 6'd63, 1'b1);
		send_ramp(24'hffffff, 24'h000000, 6'd63, 1'b0);
		send_ramp(24'h5a5a5a, 24'ha5a5a5, 6'd63, 1'b1);
		send_ramp(24'ha5a5a5, 24'h5a5a5a, 6'd42, 1'b0);
		send_ramp(24'h000000, 24'h3e3e3e, 6'd63, 1'b1);
		drain_ramps();
	endtask

	task automatic test_mixed_direction();
		send_ramp(24'hff00ff, 24'h00ff00, 6'd7, 1'b1);
		send_ramp(24'h00ff00, 24'hff00ff, 6'd2, 1'b0);
		send_ramp(24'h808080, 24'h808080, 6'd5, 1'b1);
		send_ramp(24'h10f020, 24'hf01080, 6'd3, 1'b1);
		send_ramp(24'h01fe7f, 24'hfe0180, 6'd21, 1'b0);
		send_ramp(24'h000001, 24'h0000ff, 6'd63, 1'b1);
		send_ramp(24'hc0ffee, 24'h3f0011, 6'd16, 1'b0);
		send_ramp(24'h0a0b0c, 24'h0c0b0a, 6'd4, 1'b1);
		drain_ramps();
	endtask

	task automatic test_random_ramps(input int count);
		logic [23:0]                 from;
		logic [23:0]                 to;
		logic [rcrg_pkg::STEP_W-1:0] steps;
		for (int i = 0; i < count; i++) begin
			from = random_color();
			to = ($urandom_range(0, 9) == 0) ? from : random_color();
			steps = ($urandom_range(0, 9) < 8) ? rcrg_pkg::STEP_W'($urandom_range(0, 15))
				: rcrg_pkg::STEP_W'($urandom_range(0, 63));
			send_ramp(from, to, steps, 1'($urandom_range(0, 1)));
		end
		drain_ramps();
	endtask

	initial begin
		arst_n      = 1'b0;
		push        = 1'b0;
		start_color = '0;
		end_color   = '0;
		step_count  = '0;
		emit_start  = 1'b0;
		mismatches  = 0;
		send_idle_pct = 8;
		pop_idle_pct  = 60;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_zero_and_one_step();
		test_full_span();
		test_mixed_direction();
		test_random_ramps(33);
		send_idle_pct = 60;
		pop_idle_pct  = 8;
		test_random_ramps(33);
		send_idle_pct = 0;
		pop_idle_pct  = 0;
		test_random_ramps(34);
		if (ramp_expected.size() != 0) begin
			report_mismatch($sformatf("%0d colors never arrived", ramp_expected.size()));
		end
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule

FILE: files.f
+incdir+sv
sv/rcrg_pkg.sv
sv/rcrg_front.sv
sv/rcrg_queue.sv
sv/rcrg_back.sv
sv/rgb_color_ramp_generator_core.sv
verif/rgb_color_ramp_generator_core_tb.sv
